// ===== rtl/core/assert_macros.svh =====
// concurrent assertion helpers, sampled on clk_i with reset rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PLEN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define PLEN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLEN_ASSERT(lbl, prop, msg)
`define PLEN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/plen_pkg.sv =====
package plen_pkg;

  localparam int unsigned DefDepth     = 16;
  localparam int unsigned DefDataWidth = 32;

  typedef enum logic [1:0] {
    CmdInsert = 2'd0,
    CmdDelete = 2'd1,
    CmdRead   = 2'd2,
    CmdNop    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusFull   = 2'd1,
    StatusAbsent = 2'd2
  } status_e;

  // per-beat control broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } ctrl_t;

endpackage

// ===== rtl/core/plen_cell.sv =====
module plen_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned DATA_WIDTH = plen_pkg::DefDataWidth
) (
  input  logic                         clk_i,
  input  plen_pkg::ctrl_t              ctrl_i,
  input  logic [IDX_W-1:0]             slot_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic signed [DATA_WIDTH-1:0] left_i,
  input  logic signed [DATA_WIDTH-1:0] right_i,
  output logic signed [DATA_WIDTH-1:0] data_o,
  output logic signed [DATA_WIDTH-1:0] read_o
);

  logic signed [DATA_WIDTH-1:0] data_q, data_d;
  logic                         hit, above;

  assign hit   = (slot_i == IDX_W'(IDX));
  assign above = (IDX_W'(IDX) > slot_i);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (hit) begin
        data_d = value_i;
      end else if (above) begin
        data_d = left_i;
      end
    end else if (ctrl_i.del && (hit || above)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign read_o = (ctrl_i.rd && hit) ? data_q : '0;

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Ordered list of up to DEPTH signed values held in a row of cells, one entry
// per cell. Each beat carries insert, delete or read at a 1-based position;
// insert and delete shift every cell at or above the slot toward its neighbor
// in the same cycle, so one command completes per clock and a new beat is
// taken every cycle while the result register is free or being drained.
// Every command returns one result beat in the cycle after it is accepted, with
// status (ok, list full, position not present) and the length after the
// command. Insert past the end appends and insert at position zero goes to
// the head. Storage has no reset; only the length counter and out_valid reset.
`include "assert_macros.svh"

module positional_list_engine #(
  parameter int unsigned DEPTH      = plen_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = plen_pkg::DefDataWidth,
  localparam int unsigned IdxW      = $clog2(DEPTH),
  localparam int unsigned CntW      = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   command_i,
  input  logic [CntW-1:0]              position_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] read_value_o,
  output logic [1:0]                   status_o,
  output logic [CntW-1:0]              length_o
);

  logic [CntW-1:0]              count_q, count_d;
  logic                         out_valid_q;
  logic signed [DATA_WIDTH-1:0] read_value_q;
  plen_pkg::status_e            status_q, status_d;
  logic [CntW-1:0]              length_q;

  logic                         in_fire, full, in_range;
  plen_pkg::cmd_e               cmd;
  plen_pkg::ctrl_t              ctrl;
  logic [CntW:0]                pos_ext, pos_lim, pos_ins;
  logic [CntW:0]                ins_m1;
  logic [CntW-1:0]              acc_m1;
  logic [IdxW-1:0]              slot;
  logic signed [DATA_WIDTH-1:0] data_w [DEPTH];
  logic signed [DATA_WIDTH-1:0] read_w [DEPTH];
  logic signed [DATA_WIDTH-1:0] read_any;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign cmd        = plen_pkg::cmd_e'(command_i);
  assign full       = (count_q == CntW'(DEPTH));
  assign in_range   = (position_i != '0) && (position_i <= count_q);

  // insert slot: clamp to head and to one past the tail
  always_comb begin
    pos_ext = {1'b0, position_i};
    pos_lim = {1'b0, count_q} + (CntW + 1)'(1);
    if (position_i == '0) begin
      pos_ins = (CntW + 1)'(1);
    end else if (pos_ext > pos_lim) begin
      pos_ins = pos_lim;
    end else begin
      pos_ins = pos_ext;
    end
    ins_m1 = pos_ins - (CntW + 1)'(1);
    acc_m1 = position_i - CntW'(1);
    slot   = (cmd == plen_pkg::CmdInsert) ? ins_m1[IdxW-1:0] : acc_m1[IdxW-1:0];
  end

  always_comb begin
    ctrl.ins = in_fire && (cmd == plen_pkg::CmdInsert) && !full;
    ctrl.del = in_fire && (cmd == plen_pkg::CmdDelete) && in_range;
    ctrl.rd  = (cmd == plen_pkg::CmdRead) && in_range;
  end

  always_comb begin
    status_d = plen_pkg::StatusOk;
    unique case (cmd) inside
      plen_pkg::CmdInsert: if (full) status_d = plen_pkg::StatusFull;
      plen_pkg::CmdDelete,
      plen_pkg::CmdRead:   if (!in_range) status_d = plen_pkg::StatusAbsent;
      default:             status_d = plen_pkg::StatusOk;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_head
      assign left_w = value_i;
    end else begin : g_mid
      assign left_w = data_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_tail
      assign right_w = data_w[g];
    end else begin : g_body
      assign right_w = data_w[g+1];
    end

    plen_cell #(
      .IDX        (g),
      .IDX_W      (IdxW),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .slot_i  (slot),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data_w[g]),
      .read_o  (read_w[g])
    );
  end

  always_comb begin
    read_any = '0;
    for (int k = 0; k < DEPTH; k++) begin
      read_any = read_any | read_w[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      read_value_q <= read_any;
      status_q     <= status_d;
      length_q     <= count_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign length_o     = length_q;

  `PLEN_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "length beyond depth")
  `PLEN_ASSERT_NEXT(a_ins_grows, ctrl.ins, count_q == $past(count_q) + CntW'(1),
                    "insert did not grow the list")
  `PLEN_ASSERT_NEXT(a_idle_holds, !in_fire, $stable(count_q),
                    "length moved without a beat")
  `PLEN_ASSERT(a_full_len, !(out_valid_q && status_q == plen_pkg::StatusFull) ||
               (length_q == CntW'(DEPTH)), "full status with spare room")
  `PLEN_ASSERT(a_read_ok, !(out_valid_q && read_value_q != '0) ||
               (status_q == plen_pkg::StatusOk), "data returned on failed command")

endmodule

// ===== sim/positional_list_engine_tb.sv =====
module positional_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ListDepth = plen_pkg::DefDepth;
  localparam int unsigned DataW     = plen_pkg::DefDataWidth;
  localparam int unsigned CntW      = $clog2(ListDepth + 1);
  localparam int          IdleLimit = 4000;
  localparam int          RandItems = 1300;

  typedef struct {
    bit                       hold;
    plen_pkg::cmd_e           cmd;
    logic [CntW-1:0]          pos;
    logic signed [DataW-1:0]  val;
  } list_cmd_t;

  typedef struct {
    logic signed [DataW-1:0]  rd;
    plen_pkg::status_e        st;
    logic [CntW-1:0]          len;
  } list_res_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               command_i    = plen_pkg::CmdNop;
  logic [CntW-1:0]          position_i   = '0;
  logic signed [DataW-1:0]  value_i      = '0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic signed [DataW-1:0]  read_value_o;
  logic [1:0]               status_o;
  logic [CntW-1:0]          length_o;

  list_cmd_t                cmd_q[$];
  list_res_t                result_q[$];
  list_cmd_t                cur_cmd;

  logic signed [DataW-1:0]  shadow_mem [ListDepth];
  int                       shadow_len   = 0;
  int                       gen_len      = 0;
  int                       errors       = 0;
  int                       idle_cycles  = 0;
  int                       gap_left     = 0;
  int                       stall_left   = 0;
  bit                       in_quiet     = 1'b0;
  bit                       out_quiet    = 1'b0;

  positional_list_engine #(
    .DEPTH      (ListDepth),
    .DATA_WIDTH (DataW)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .length_o     (length_o)
  );

  always #4 clk_i = ~clk_i;

  // applies one command to the shadow list and returns the result it gives
  function automatic list_res_t apply_list_cmd(list_cmd_t c);
    list_res_t r;
    int        p;
    r.rd = '0;
    r.st = plen_pkg::StatusOk;
    p    = int'(c.pos);
    case (c.cmd)
      plen_pkg::CmdInsert: begin
        if (shadow_len >= ListDepth) begin
          r.st = plen_pkg::StatusFull;
        end else begin
          if (p == 0) p = 1;
          if (p > shadow_len + 1) p = shadow_len + 1;
          for (int i = shadow_len; i > p - 1; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[p-1] = c.val;
          shadow_len++;
        end
      end
      plen_pkg::CmdDelete: begin
        if (p == 0 || p > shadow_len) begin
          r.st = plen_pkg::StatusAbsent;
        end else begin
          for (int i = p - 1; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_len--;
        end
      end
      plen_pkg::CmdRead: begin
        if (p == 0 || p > shadow_len) r.st = plen_pkg::StatusAbsent;
        else r.rd = shadow_mem[p-1];
      end
      default: ;
    endcase
    r.len = CntW'(shadow_len);
    return r;
  endfunction

  function automatic int pick_idle(inout bit quiet);
    int r;
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic add_cmd(plen_pkg::cmd_e cmd, int pos, logic signed [DataW-1:0] val);
    list_cmd_t c;
    c.hold = 1'b0;
    c.cmd  = cmd;
    c.pos  = CntW'(pos);
    c.val  = val;
    cmd_q.push_back(c);
    if (cmd == plen_pkg::CmdInsert && gen_len < ListDepth) gen_len++;
    if (cmd == plen_pkg::CmdDelete && pos >= 1 && pos <= gen_len) gen_len--;
  endtask

  task automatic add_hold();
    list_cmd_t c;
    c.hold = 1'b1;
    c.cmd  = plen_pkg::CmdNop;
    c.pos  = '0;
    c.val  = '0;
    cmd_q.push_back(c);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    list_cmd_t nxt;
    bit        launch;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      command_i  <= plen_pkg::CmdNop;
      position_i <= '0;
      value_i    <= '0;
      gap_left   = 0;
    end else begin
      launch = 1'b0;
      if (in_valid_i && in_ready_o) begin
        result_q.push_back(apply_list_cmd(cur_cmd));
        gap_left = pick_idle(in_quiet);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() != 0) begin
          if (cmd_q[0].hold) begin
            if (result_q.size() == 0) void'(cmd_q.pop_front());
          end else begin
            nxt    = cmd_q.pop_front();
            launch = 1'b1;
          end
        end
        in_valid_i <= launch;
        if (launch) begin
          cur_cmd = nxt;
          command_i  <= nxt.cmd;
          position_i <= nxt.pos;
          value_i    <= nxt.val;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    list_res_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: read_value %0d status %0d length %0d",
                   $time, read_value_o, status_o, length_o);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (read_value_o !== want.rd) begin
            $display("%0t: read_value expected %0d got %0d", $time, want.rd, read_value_o);
            errors++;
          end
          if (status_o !== want.st) begin
            $display("%0t: status expected %0d got %0d", $time, want.st, status_o);
            errors++;
          end
          if (length_o !== want.len) begin
            $display("%0t: length expected %0d got %0d", $time, want.len, length_o);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_idle(out_quiet);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int             mode;
    int             r;
    int             pos;
    plen_pkg::cmd_e cmd;

    // empty list, head and tail inserts, value extremes, out-of-range positions
    add_cmd(plen_pkg::CmdRead,   1,  32'sd0);
    add_cmd(plen_pkg::CmdDelete, 1,  32'sd0);
    add_cmd(plen_pkg::CmdInsert, 0,  32'sh7fffffff);
    add_cmd(plen_pkg::CmdInsert, 31, 32'sh80000000);
    add_cmd(plen_pkg::CmdInsert, 1,  -32'sd1);
    add_cmd(plen_pkg::CmdInsert, 2,  32'sd0);
    add_cmd(plen_pkg::CmdInsert, 17, 32'sh5a5a5a5a);
    add_cmd(plen_pkg::CmdRead,   0,  32'sd0);
    add_cmd(plen_pkg::CmdRead,   6,  32'sd0);
    add_cmd(plen_pkg::CmdRead,   1,  32'sd0);
    add_cmd(plen_pkg::CmdRead,   3,  32'sd0);
    add_cmd(plen_pkg::CmdRead,   5,  32'sd0);
    add_cmd(plen_pkg::CmdDelete, 0,  32'sd0);
    add_cmd(plen_pkg::CmdDelete, 31, 32'sd0);
    add_cmd(plen_pkg::CmdDelete, 2,  32'sd0);
    add_cmd(plen_pkg::CmdNop,    5,  32'sh12345678);
    add_cmd(plen_pkg::CmdRead,   2,  32'sd0);
    add_cmd(plen_pkg::CmdDelete, 4,  32'sd0);
    add_cmd(plen_pkg::CmdRead,   4,  32'sd0);
    add_hold();

    mode = 0;
    for (int n = 0; n < RandItems; n++) begin
      if (n % 64 == 0) mode = $urandom_range(0, 2);
      if (n == RandItems / 2) add_hold();
      r = $urandom_range(0, 99);
      case (mode)
        0:       cmd = (r < 60) ? plen_pkg::CmdInsert : (r < 75) ? plen_pkg::CmdDelete :
                       (r < 98) ? plen_pkg::CmdRead : plen_pkg::CmdNop;
        1:       cmd = (r < 15) ? plen_pkg::CmdInsert : (r < 70) ? plen_pkg::CmdDelete :
                       (r < 98) ? plen_pkg::CmdRead : plen_pkg::CmdNop;
        default: cmd = (r < 35) ? plen_pkg::CmdInsert : (r < 65) ? plen_pkg::CmdDelete :
                       (r < 98) ? plen_pkg::CmdRead : plen_pkg::CmdNop;
      endcase
      if ($urandom_range(0, 99) < 8) pos = $urandom_range(0, 31);
      else if (cmd == plen_pkg::CmdInsert) pos = $urandom_range(1, gen_len + 1);
      else pos = (gen_len == 0) ? 1 : $urandom_range(1, gen_len);
      add_cmd(cmd, pos, $urandom);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (errors == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
